// File: rtl/mpq_pkg.sv
package mpq_pkg;

    localparam int MPQ_CAPACITY = 64;
    localparam int KEY_W        = 32;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_EXTRACT = 2'd2
    } t_command;

    typedef struct packed {
        t_command                 command;
        logic signed [KEY_W-1:0]  key_in;
    } t_cmd_item;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key_out;
        logic                     is_empty;
        logic                     dropped;
    } t_res_item;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic                     ins;
        logic                     ext;
        logic signed [KEY_W-1:0]  key;
    } t_cell_ctl;

endpackage

// File: rtl/mpq_stream_if.sv
interface mpq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mpq_cell.sv
module mpq_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpq_pkg::t_cell_ctl                i_ctl,
    input  logic signed [mpq_pkg::KEY_W-1:0]  i_left_key,
    input  logic                              i_left_valid,
    input  logic                              i_left_lt,
    input  logic signed [mpq_pkg::KEY_W-1:0]  i_right_key,
    input  logic                              i_right_valid,
    output logic signed [mpq_pkg::KEY_W-1:0]  o_key,
    output logic                              o_valid,
    output logic                              o_lt
);
    import mpq_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    r_valid;
    logic                    n_valid;
    logic                    w_lt;

    // an empty cell counts as holding +infinity
    assign w_lt = !r_valid || (i_ctl.key < r_key);

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.ins && w_lt) begin
            if (i_left_lt) begin
                n_key   = i_left_key;
                n_valid = i_left_valid;
            end else begin
                n_key   = i_ctl.key;
                n_valid = 1'b1;
            end
        end else if (i_ctl.ext) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
    assign o_lt    = w_lt;

endmodule

// File: rtl/min_priority_queue.sv
// Channel   Dir  Modport  Payload      Notes
// i_cmd     in   sink     t_cmd_item   command, key_in
// o_res     out  source   t_res_item   key_out, is_empty, dropped; one per item
//
// One item per cycle unless stalled: a sorted chain of CAPACITY cells holds
// the keys, smallest in cell 0; each insert or extract shifts it by one cell.
// The result leaves through one output register, in the cycle after acceptance.
// i_cmd.ready is low only while a result is held and o_res.ready is low.
// Synchronous active-low reset empties the chain and the output register.
module min_priority_queue #(
    parameter int CAPACITY = mpq_pkg::MPQ_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpq_stream_if.sink   i_cmd,
    mpq_stream_if.source o_res
);
    import mpq_pkg::*;

    t_cmd_item               w_cmd;
    t_cell_ctl               w_ctl;
    t_res_item               r_res;
    t_res_item               n_res;
    logic                    r_out_valid;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;
    logic signed [KEY_W-1:0] w_key [CAPACITY];
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_lt;

    assign w_cmd       = i_cmd.payload;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = w_valid[CAPACITY-1];
    assign w_empty     = !w_valid[0];

    always_comb begin
        w_ctl.key = w_cmd.key_in;
        w_ctl.ins = 1'b0;
        w_ctl.ext = 1'b0;
        n_res     = '0;
        case (w_cmd.command)
            CMD_INSERT: begin
                w_ctl.ins     = w_accept && !w_full;
                n_res.key_out = w_cmd.key_in;
                n_res.dropped = w_full;
            end
            CMD_PEEK, CMD_EXTRACT: begin
                w_ctl.ext      = w_accept && !w_empty && (w_cmd.command == CMD_EXTRACT);
                n_res.is_empty = w_empty;
                n_res.key_out  = w_empty ? '0 : w_key[0];
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_W-1:0] w_lkey;
        logic                    w_lvalid;
        logic                    w_llt;
        logic signed [KEY_W-1:0] w_rkey;
        logic                    w_rvalid;

        if (i == 0) begin : g_head
            assign w_lkey   = '0;
            assign w_lvalid = 1'b0;
            assign w_llt    = 1'b0;
        end else begin : g_mid
            assign w_lkey   = w_key[i-1];
            assign w_lvalid = w_valid[i-1];
            assign w_llt    = w_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_body
            assign w_rkey   = w_key[i+1];
            assign w_rvalid = w_valid[i+1];
        end

        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_key    (w_lkey),
            .i_left_valid  (w_lvalid),
            .i_left_lt     (w_llt),
            .i_right_key   (w_rkey),
            .i_right_valid (w_rvalid),
            .o_key         (w_key[i]),
            .o_valid       (w_valid[i]),
            .o_lt          (w_lt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_res       <= n_res;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_res;

    // occupied cells always form an unbroken run from cell 0
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("occupied cells not contiguous");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted item gave no result");

    a_extract_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd.command == CMD_EXTRACT) && !w_empty) |=>
        ($countones(w_valid) + 1 == $past($countones(w_valid))))
        else $error("extract did not remove exactly one key");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd.command == CMD_INSERT) && !w_full) |=>
        ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add exactly one key");

    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_key[0] <= w_key[1]))
        else $error("head cell is not the minimum");

endmodule
